FILE: rtl/bdq_pkg.sv
// Package for the bounded deque with value removal.
// Holds widths, opcodes, controller states and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

  // Payload widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned DEPTH_DEF = 16;

  // Operation codes of an input transaction
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_DROP_FRONT = 3'd2,
    OP_DROP_BACK  = 3'd3,
    OP_REMOVE_EQ  = 3'd4
  } op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_in;
    logic push_front;
    logic push_back;
    logic drop_front;
    logic drop_back;
    logic fail;
    logic scan_start;
    logic scan_next;
    logic shift_read;
    logic shift_write;
    logic remove_commit;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic match;
    logic last;
    logic next_last;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/bdq_if.sv
// Handshake interfaces for the input and result channels.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

interface bdq_in_if import bdq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [LEN_W-1:0] length;

  modport source (output valid, output ok, output length, input ready);
  modport sink   (input valid, input ok, input length, output ready);
endinterface

FILE: rtl/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bdq_ctrl.sv
// Controller state machine: decodes the operation and sequences scan and shift.
// Depends on bdq_pkg; drives the datapath through cmd_t, reads status_t.
`timescale 1ns / 1ps

module bdq_ctrl import bdq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (status_i.op == OP_REMOVE_EQ && !status_i.empty) state_d = ST_SCAN_RD;
        else state_d = ST_FINISH;
      end
      ST_SCAN_RD: state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (status_i.match && !status_i.last) state_d = ST_SHIFT_RD;
        else if (status_i.match || status_i.last) state_d = ST_FINISH;
        else state_d = ST_SCAN_RD;
      end
      ST_SHIFT_RD: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        if (status_i.next_last) state_d = ST_FINISH;
        else state_d = ST_SHIFT_RD;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.latch_in  = in_valid_i;
      end
      ST_DECODE: begin
        case (status_i.op)
          OP_PUSH_FRONT: begin
            cmd_o.push_front = !status_i.full;
            cmd_o.fail       = status_i.full;
          end
          OP_PUSH_BACK: begin
            cmd_o.push_back = !status_i.full;
            cmd_o.fail      = status_i.full;
          end
          OP_DROP_FRONT: begin
            cmd_o.drop_front = !status_i.empty;
            cmd_o.fail       = status_i.empty;
          end
          OP_DROP_BACK: begin
            cmd_o.drop_back = !status_i.empty;
            cmd_o.fail      = status_i.empty;
          end
          OP_REMOVE_EQ: begin
            cmd_o.scan_start = !status_i.empty;
            cmd_o.fail       = status_i.empty;
          end
          default: cmd_o.fail = 1'b1;
        endcase
      end
      ST_SCAN_CMP: begin
        if (status_i.match) begin
          // match at the back needs no shifting
          cmd_o.remove_commit = status_i.last;
        end else if (status_i.last) begin
          cmd_o.fail = 1'b1;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_SHIFT_RD: cmd_o.shift_read = 1'b1;
      ST_SHIFT_WR: begin
        cmd_o.shift_write   = 1'b1;
        cmd_o.remove_commit = status_i.next_last;
      end
      ST_FINISH: cmd_o.load_out = status_i.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // Input only taken while idle
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch_in |=> state_q == ST_DECODE)
    else $error("accepted transaction did not reach decode");

  // A finished result always returns to idle once the slot is free
  a_finish_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && status_i.out_free) |=> state_q == ST_IDLE)
    else $error("finish did not return to idle");

  // Shift writes only follow a shift read
  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT_WR |-> $past(state_q) == ST_SHIFT_RD)
    else $error("shift write without preceding read");
`endif

endmodule

FILE: rtl/bdq_dp.sv
// Datapath: circular entry store in RAM, head and count, scan and shift
// pointers, and the result register. Depends on bdq_pkg and bdq_ram.
`timescale 1ns / 1ps

module bdq_dp import bdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [OP_W-1:0]         in_opcode_i,
  input  logic signed [VAL_W-1:0] in_value_i,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    out_ok_o,
  output logic [LEN_W-1:0]        out_length_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  // Registers
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     idx_q, idx_d;
  op_e               op_q;
  logic [VAL_W-1:0]  val_q;
  logic              ok_q;
  logic              out_valid_q;
  logic              res_ok_q;
  logic [LEN_W-1:0]  res_len_q;

  // Address arithmetic with wrap at DEPTH
  logic [AW-1:0]    head_inc, head_dec, ptr_inc, tail;
  logic [AW:0]      tail_sum;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;
  logic             out_free;

  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
  assign ptr_inc  = (ptr_q == LAST_IDX) ? '0 : ptr_q + AW'(1);
  assign tail_sum = (AW + 1)'(head_q) + (AW + 1)'(count_q);
  assign tail     = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);

  // RAM port selection
  assign we    = cmd_i.push_front | cmd_i.push_back | cmd_i.shift_write;
  assign waddr = cmd_i.push_front ? head_dec : (cmd_i.push_back ? tail : ptr_q);
  assign wdata = cmd_i.shift_write ? rdata : val_q;
  assign raddr = cmd_i.shift_read ? ptr_inc : ptr_q;

  bdq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Head and count update
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.push_front) begin
      head_d  = head_dec;
      count_d = count_q + CW'(1);
    end
    if (cmd_i.push_back) count_d = count_q + CW'(1);
    if (cmd_i.drop_front) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end
    if (cmd_i.drop_back || cmd_i.remove_commit) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Scan/shift pointer and logical index
  always_comb begin
    ptr_d = ptr_q;
    idx_d = idx_q;
    if (cmd_i.scan_start) begin
      ptr_d = head_q;
      idx_d = '0;
    end else if (cmd_i.scan_next || cmd_i.shift_write) begin
      ptr_d = ptr_inc;
      idx_d = idx_q + CW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    idx_q <= idx_d;
    if (cmd_i.latch_in) begin
      op_q  <= op_e'(in_opcode_i);
      val_q <= in_value_i;
    end
    if (cmd_i.fail) ok_q <= 1'b0;
    else if (cmd_i.push_front || cmd_i.push_back || cmd_i.drop_front ||
             cmd_i.drop_back || cmd_i.remove_commit) ok_q <= 1'b1;
    if (cmd_i.load_out) begin
      res_ok_q  <= ok_q;
      res_len_q <= LEN_W'(count_q);
    end
  end

  // Result register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_ok_o     = res_ok_q;
  assign out_length_o = res_len_q;

  // Status
  assign status_o.op        = op_q;
  assign status_o.empty     = (count_q == '0);
  assign status_o.full      = (count_q == DEPTH_C);
  assign status_o.match     = (rdata == val_q);
  assign status_o.last      = ((CW + 1)'(idx_q) + (CW + 1)'(1) == (CW + 1)'(count_q));
  assign status_o.next_last = ((CW + 1)'(idx_q) + (CW + 1)'(2) == (CW + 1)'(count_q));
  assign status_o.out_free  = out_free;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("count exceeds depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_front || cmd_i.push_back) |-> count_q != DEPTH_C)
    else $error("push into full store");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_front || cmd_i.push_back) |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not grow count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> out_free)
    else $error("result loaded over a pending result");
`endif

endmodule

FILE: rtl/bounded_deque_with_value_removal_unit.sv
// Top level of the bounded deque with value removal.
// Depends on bdq_pkg, bdq_if, bdq_ctrl, bdq_dp (and bdq_ram below it).
//
//   channel  | dir | payload                          | handshake
//   in_i     | in  | opcode[2:0], value[31:0] signed  | valid/ready
//   out_o    | out | ok, length[4:0]                  | valid/ready
//
// Push and drop pass through accept, execute, and load the result register.
// Remove-by-value reads then compares each entry scanned, and reads then writes
// each entry shifted: the single-read-port RAM with registered read needs both.
// Reset clears count and head; stored entries are undefined until written.
// A result waits in the output register; finishing the next transaction stalls
// only while that register is still held.
`timescale 1ns / 1ps

module bounded_deque_with_value_removal_unit import bdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_in_if.sink    in_i,
  bdq_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready = in_ready;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_opcode_i  (in_i.opcode),
    .in_value_i   (in_i.value),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_ok_o     (out_o.ok),
    .out_length_o (out_o.length)
  );

endmodule
